/* rtl/bline_pkg.sv */
// Package with the shared constants of the line point generator.
package bline_pkg;

  // Default coordinate width of the grid (grid is 2^COORD_BITS on a side).
  localparam int COORD_BITS_DEF = 6;

  // Fixed widths of the pass-through fields.
  localparam int ELEM_BITS  = 9;
  localparam int ORDER_BITS = 8;

  // Depth of the setup queue between the front and the walker.
  localparam int QDEPTH = 2;

  // Width of one setup record for a given coordinate width:
  // a1, b1, a2, span_a, span_b (each coordinate wide), steep, down, element, order.
  function automatic int rec_bits(input int cb);
    return 5 * cb + 2 + ELEM_BITS + ORDER_BITS;
  endfunction

endpackage

/* rtl/bline_front.sv */
// Front stage: takes a line item, classifies it and registers its setup record.
module bline_front #(
  parameter int COORD_BITS = bline_pkg::COORD_BITS_DEF,
  parameter int IN_W       = 48,
  parameter int REC_W      = bline_pkg::rec_bits(bline_pkg::COORD_BITS_DEF)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_data,
  output logic             rec_valid,
  input  logic             rec_ready,
  output logic [REC_W-1:0] rec_data
);
  import bline_pkg::*;

  localparam int C = COORD_BITS;

  logic [C-1:0]          x1, y1, x2, y2;
  logic [ELEM_BITS-1:0]  elem;
  logic [ORDER_BITS-1:0] tag;
  logic [C-1:0]          dx, dy;
  logic                  steep;
  logic [C-1:0]          pa1, pb1, pa2, pb2;
  logic [C-1:0]          a1, b1, a2, b2;
  logic [C-1:0]          span_a, span_b;
  logic                  down;
  logic [REC_W-1:0]      rec_next;

  assign x1   = in_data[C-1:0];
  assign y1   = in_data[2*C-1:C];
  assign x2   = in_data[3*C-1:2*C];
  assign y2   = in_data[4*C-1:3*C];
  assign elem = in_data[4*C+ELEM_BITS-1:4*C];
  assign tag  = in_data[4*C+ELEM_BITS+ORDER_BITS-1:4*C+ELEM_BITS];

  always_comb begin
    dx    = (x2 > x1) ? (x2 - x1) : (x1 - x2);
    dy    = (y2 > y1) ? (y2 - y1) : (y1 - y2);
    steep = (dy > dx);
    if (steep) begin
      pa1 = y1; pb1 = x1; pa2 = y2; pb2 = x2;
    end else begin
      pa1 = x1; pb1 = y1; pa2 = x2; pb2 = y2;
    end
    // Order the endpoints so that the major coordinate rises.
    if (pa1 > pa2) begin
      a1 = pa2; b1 = pb2; a2 = pa1; b2 = pb1;
    end else begin
      a1 = pa1; b1 = pb1; a2 = pa2; b2 = pb2;
    end
    span_a   = a2 - a1;
    span_b   = (b2 > b1) ? (b2 - b1) : (b1 - b2);
    down     = !(b1 < b2);
    rec_next = {tag, elem, down, steep, span_b, span_a, a2, b1, a1};
  end

  assign in_ready = !rec_valid || rec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (in_ready) begin
      rec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rec_data <= rec_next;
    end
  end

endmodule

/* rtl/bline_queue.sv */
// Short queue of setup records between the front stage and the walker.
module bline_queue #(
  parameter int REC_W = bline_pkg::rec_bits(bline_pkg::COORD_BITS_DEF)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REC_W-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [REC_W-1:0] out_data
);
  import bline_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  logic [REC_W-1:0] mem [QDEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign in_ready  = (count != CW'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

/* rtl/bline_walk.sv */
// Walker: steps along one line per setup record and emits one point per cycle while the output is not stalled.
module bline_walk #(
  parameter int COORD_BITS = bline_pkg::COORD_BITS_DEF,
  parameter int OUT_W      = 32,
  parameter int REC_W      = bline_pkg::rec_bits(bline_pkg::COORD_BITS_DEF)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rec_valid,
  output logic             rec_ready,
  input  logic [REC_W-1:0] rec_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data,
  output logic             out_last
);
  import bline_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int EB = C + 2;   // stored error, signed
  localparam int EW = C + 4;   // error arithmetic, signed

  // Unpacked setup record.
  logic [C-1:0]          r_a1, r_b1, r_a2, r_span_a, r_span_b;
  logic                  r_steep, r_down;
  logic [ELEM_BITS-1:0]  r_elem;
  logic [ORDER_BITS-1:0] r_tag;

  // Walk state.
  logic                  busy;
  logic [C-1:0]          a, b, a_end, span_a, span_b;
  logic signed [EB-1:0]  err;
  logic                  steep, down;
  logic [ELEM_BITS-1:0]  elem;
  logic [ORDER_BITS-1:0] tag;

  logic                  adv, load, at_end, step;
  logic signed [EW-1:0]  err_sum;
  logic [EB-1:0]         err_next;
  logic [C-1:0]          pt_x, pt_y;

  assign {r_tag, r_elem, r_down, r_steep, r_span_b, r_span_a, r_a2, r_b1, r_a1} = rec_data;

  assign rec_ready = !busy;
  assign load      = rec_valid && !busy;
  assign adv       = busy && (!out_valid || out_ready);
  assign at_end    = (a == a_end);

  always_comb begin
    err_sum  = EW'(err) + $signed({{(EW-C){1'b0}}, span_b});
    step     = ((err_sum <<< 1) >= $signed({{(EW-C){1'b0}}, span_a}));
    err_next = step ? EB'(err_sum - $signed({{(EW-C){1'b0}}, span_a})) : EB'(err_sum);
    pt_x     = steep ? b : a;
    pt_y     = steep ? a : b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (adv && at_end) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a      <= r_a1;
      b      <= r_b1;
      a_end  <= r_a2;
      span_a <= r_span_a;
      span_b <= r_span_b;
      steep  <= r_steep;
      down   <= r_down;
      elem   <= r_elem;
      tag    <= r_tag;
      err    <= '0;
    end else if (adv) begin
      a   <= a + 1'b1;
      err <= err_next;
      if (step) begin
        b <= down ? b - 1'b1 : b + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= OUT_W'({tag, elem, pt_y, pt_x});
      out_last <= at_end;
    end
  end

endmodule

/* rtl/bresenham_line_points_core.sv */
// A line item passes the front register, the queue and the walker load before its first
// point leaves the walker's output register on the master side.
// The walker gives one point per cycle while the master side does not stall, and between
// lines it spends a load step in which it loads the next setup record from the queue.
// The front stage and a two-entry setup queue take new items while the walker is busy.
// Reset (rst, synchronous, active high) empties the front stage, the queue and the output.
module bresenham_line_points_core #(
  parameter int COORD_BITS = bline_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + bline_pkg::ELEM_BITS + bline_pkg::ORDER_BITS + 7)
                          / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + bline_pkg::ELEM_BITS + bline_pkg::ORDER_BITS + 7)
                          / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  // Line items.
  input  logic            s_tvalid,
  output logic            s_tready,
  // Fields from bit 0 up: start_x, start_y, end_x, end_y, element_code, order_tag, zero pad.
  input  logic [IN_W-1:0] s_tdata,
  // Point items.
  output logic            m_tvalid,
  input  logic            m_tready,
  // Fields from bit 0 up: point_x, point_y, point_element, point_order, zero pad.
  output logic [OUT_W-1:0] m_tdata,
  // last_point: high on the final point of a line.
  output logic            m_tlast
);
  import bline_pkg::*;

  localparam int REC_W = rec_bits(COORD_BITS);

  // Front to queue.
  logic             f_valid, f_ready;
  logic [REC_W-1:0] f_data;
  // Queue to walker.
  logic             q_valid, q_ready;
  logic [REC_W-1:0] q_data;

  // The front stage finds the steep case, orders the endpoints so the major
  // coordinate rises, and works out both spans and the minor direction.
  bline_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .REC_W      (REC_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec_data  (f_data)
  );

  // Setup records wait here so the front can keep taking items during a long walk.
  bline_queue #(
    .REC_W (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  // The walker runs the error accumulator along the major axis and drives the
  // registered output stage, which holds a point while the master side stalls.
  bline_walk #(
    .COORD_BITS (COORD_BITS),
    .OUT_W      (OUT_W),
    .REC_W      (REC_W)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (q_valid),
    .rec_ready (q_ready),
    .rec_data  (q_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
